@@ rtl/gsma_pkg.sv @@
`default_nettype none

package gsma_pkg;

  localparam int MAX_ROWS    = 1024;
  localparam int MAX_COLUMNS = 1024;

  localparam int SIZE_W  = 11;
  localparam int ADDR_W  = $clog2(MAX_ROWS + 1);
  localparam int COND_W  = 16;
  localparam int COEF_W  = 16;
  localparam int CFG_W   = 64;
  localparam int NODE_W  = 21;
  localparam int VALUE_W = 34;
  localparam int PROD_W  = COEF_W + COND_W + 1;
  localparam int SUM_W   = PROD_W + 2;
  localparam int DELTA_W = SIZE_W + 2;
  localparam int SELF_W  = 2 * SIZE_W;
  localparam int LANES   = 4;
  localparam int ENTRIES = 9;
  localparam int K_W     = 4;

  typedef enum logic [2:0] {
    CFG_CELL_COLUMNS = 3'd0,
    CFG_CELL_ROWS    = 3'd1,
    CFG_COEF_ROW0    = 3'd2,
    CFG_COEF_ROW1    = 3'd3,
    CFG_COEF_ROW2    = 3'd4,
    CFG_COEF_ROW3    = 3'd5
  } cfg_reg_t;

  // column offset plus one of neighborhood entry k
  function automatic logic [1:0] entry_col(input logic [K_W-1:0] k);
    logic [1:0] res;
    case (k)
      4'd0, 4'd1, 4'd2: res = 2'd0;
      4'd3, 4'd4, 4'd5: res = 2'd1;
      4'd6, 4'd7, 4'd8: res = 2'd2;
      default:          res = 2'd1;
    endcase
    return res;
  endfunction

  // row offset plus one of neighborhood entry k
  function automatic logic [1:0] entry_row(input logic [K_W-1:0] k);
    logic [1:0] res;
    case (k)
      4'd0, 4'd3, 4'd6: res = 2'd0;
      4'd1, 4'd4, 4'd7: res = 2'd1;
      4'd2, 4'd5, 4'd8: res = 2'd2;
      default:          res = 2'd1;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/grid_stencil_matrix_assembly.sv @@
// path: each entry of a node passes the node stage, the operand and multiply registers and the output register
// throughput: one entry per cycle while the output is not stalled, set by the single result port, so a node
// gives 4 to 9 entries (its clipped neighborhood); the next node is taken on the edge its last entry issues
// column buffer: one synchronous memory, read and written once per node at its row
// reset: positions at zero, sizes at one, coefficients zero; the column buffer is not cleared
`default_nettype none

module grid_stencil_matrix_assembly (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [2:0]                           cfg_index,
  input  wire logic [gsma_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [gsma_pkg::COND_W-1:0]          conductivity,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [gsma_pkg::NODE_W-1:0]               column_node,
  output logic [gsma_pkg::NODE_W-1:0]               row_node,
  output logic signed [gsma_pkg::VALUE_W-1:0]       entry_value,
  output logic                                      last_of_column
);

  localparam int SW = gsma_pkg::SIZE_W;

  // configuration
  logic [SW-1:0]               cell_columns;
  logic [SW-1:0]               cell_rows;
  logic [gsma_pkg::CFG_W-1:0]  coef_row [gsma_pkg::LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_columns <= SW'(1);
      cell_rows    <= SW'(1);
      for (int i = 0; i < gsma_pkg::LANES; i++) coef_row[i] <= '0;
    end else if (cfg_we) begin
      case (gsma_pkg::cfg_reg_t'(cfg_index))
        gsma_pkg::CFG_CELL_COLUMNS: cell_columns <= cfg_data[SW-1:0];
        gsma_pkg::CFG_CELL_ROWS:    cell_rows    <= cfg_data[SW-1:0];
        gsma_pkg::CFG_COEF_ROW0:    coef_row[0]  <= cfg_data;
        gsma_pkg::CFG_COEF_ROW1:    coef_row[1]  <= cfg_data;
        gsma_pkg::CFG_COEF_ROW2:    coef_row[2]  <= cfg_data;
        gsma_pkg::CFG_COEF_ROW3:    coef_row[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped sizes and wrapped position
  logic [SW-1:0] cols, rows, stride;
  logic [SW-1:0] col_pos, row_pos, col_pos_next, row_pos_next;
  logic [SW-1:0] c_cur, r_cur;

  always_comb begin
    if (cell_columns == '0) cols = SW'(1);
    else if (cell_columns > SW'(gsma_pkg::MAX_COLUMNS)) cols = SW'(gsma_pkg::MAX_COLUMNS);
    else cols = cell_columns;
    if (cell_rows == '0) rows = SW'(1);
    else if (cell_rows > SW'(gsma_pkg::MAX_ROWS)) rows = SW'(gsma_pkg::MAX_ROWS);
    else rows = cell_rows;
    stride = rows + SW'(1);
    c_cur  = (col_pos > cols) ? '0 : col_pos;
    r_cur  = (row_pos > rows) ? '0 : row_pos;
    if (r_cur >= rows) begin
      row_pos_next = '0;
      col_pos_next = (c_cur >= cols) ? '0 : c_cur + SW'(1);
    end else begin
      row_pos_next = r_cur + SW'(1);
      col_pos_next = c_cur;
    end
  end

  logic accept;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
    end
  end

  // previous column buffer, read-first at the node's row
  logic [gsma_pkg::COND_W-1:0] column_mem [0:gsma_pkg::MAX_ROWS];
  logic [gsma_pkg::COND_W-1:0] mem_rdata;
  logic [gsma_pkg::ADDR_W-1:0] mem_addr;

  assign mem_addr = gsma_pkg::ADDR_W'(r_cur);

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_rdata            <= column_mem[mem_addr];
      column_mem[mem_addr] <= conductivity;
    end
  end

  // neighborhood mask of the incoming node
  logic [gsma_pkg::ENTRIES-1:0] mask_new;
  logic                         c_first, c_last, r_first, r_last;

  always_comb begin
    logic [1:0] dcp, drp;
    c_first = (c_cur == '0);
    c_last  = (c_cur >= cols);
    r_first = (r_cur == '0);
    r_last  = (r_cur >= rows);
    for (int k = 0; k < gsma_pkg::ENTRIES; k++) begin
      dcp = gsma_pkg::entry_col(gsma_pkg::K_W'(k));
      drp = gsma_pkg::entry_row(gsma_pkg::K_W'(k));
      mask_new[k] = !(dcp == 2'd0 && c_first) && !(dcp == 2'd2 && c_last) &&
                    !(drp == 2'd0 && r_first) && !(drp == 2'd2 && r_last);
    end
  end

  // node stage: holds one node while its entries issue
  logic                         a_valid;
  logic [gsma_pkg::ENTRIES-1:0] a_mask;
  logic [SW-1:0]                a_c, a_r, a_stride;
  logic [gsma_pkg::LANES-1:0]   a_have;
  logic [gsma_pkg::COND_W-1:0]  a_cond00, a_cond10, a_cond11;
  logic                         a_last, issue;
  logic [gsma_pkg::K_W-1:0]     a_k;

  // pipeline stages
  logic                               m_valid, s_valid, m_adv, s_adv, o_adv;
  logic signed [gsma_pkg::COEF_W-1:0] m_coef [gsma_pkg::LANES];
  logic [gsma_pkg::COND_W-1:0]        m_cond [gsma_pkg::LANES];
  logic [SW-1:0]                      m_c, m_r, m_stride;
  logic signed [gsma_pkg::DELTA_W-1:0] m_delta;
  logic                               m_last;
  logic signed [gsma_pkg::PROD_W-1:0] s_prod [gsma_pkg::LANES];
  logic [gsma_pkg::SELF_W-1:0]        s_self;
  logic signed [gsma_pkg::DELTA_W-1:0] s_delta;
  logic                               s_last;

  assign o_adv    = !out_valid || out_ready;
  assign s_adv    = !s_valid || o_adv;
  assign m_adv    = !m_valid || s_adv;
  assign issue    = a_valid && m_adv;
  assign a_last   = (a_mask & (a_mask - 1'b1)) == '0;
  assign in_ready = !a_valid || (issue && a_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (issue && a_last) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_mask   <= mask_new;
      a_c      <= c_cur;
      a_r      <= r_cur;
      a_stride <= stride;
      a_have   <= {!c_last && !r_last, !c_last && !r_first,
                   !c_first && !r_last, !c_first && !r_first};
      a_cond00 <= mem_rdata;
      a_cond10 <= a_cond11;
      a_cond11 <= conductivity;
    end else if (issue) begin
      a_mask <= a_mask & (a_mask - 1'b1);
    end
  end

  // operand selection for the entry issued this cycle
  logic signed [gsma_pkg::COEF_W-1:0]  lane_coef [gsma_pkg::LANES];
  logic [gsma_pkg::COND_W-1:0]         lane_cond [gsma_pkg::LANES];
  logic signed [gsma_pkg::DELTA_W-1:0] delta;

  always_comb begin
    logic [1:0] dcp, drp, hi_off, lo_off;
    logic       dx, dy, ok;
    logic [1:0] lc, m;
    a_k = '0;
    for (int i = gsma_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (a_mask[i]) a_k = gsma_pkg::K_W'(i);
    end
    dcp = gsma_pkg::entry_col(a_k);
    drp = gsma_pkg::entry_row(a_k);
    lane_cond[0] = a_cond00;
    lane_cond[1] = mem_rdata;
    lane_cond[2] = a_cond10;
    lane_cond[3] = a_cond11;
    for (int l = 0; l < gsma_pkg::LANES; l++) begin
      dx     = l[1];
      dy     = l[0];
      hi_off = dcp - {1'b0, dx};
      lo_off = drp - {1'b0, dy};
      ok     = a_have[l] && (dcp >= {1'b0, dx}) && (hi_off <= 2'd1) &&
               (drp >= {1'b0, dy}) && (lo_off <= 2'd1);
      lc     = {~dx, ~dy};
      m      = {hi_off[0], lo_off[0]};
      lane_coef[l] = ok ? coef_row[lc][{m, 4'b0000} +: gsma_pkg::COEF_W] : '0;
      // cells outside the grid may hold never-written data
      if (!ok) lane_cond[l] = '0;
    end
    case (dcp)
      2'd0:    delta = -$signed({2'b00, a_stride});
      2'd2:    delta = $signed({2'b00, a_stride});
      default: delta = '0;
    endcase
    delta = delta + $signed({{(gsma_pkg::DELTA_W-2){1'b0}}, drp}) - gsma_pkg::DELTA_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_adv) begin
      m_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      for (int l = 0; l < gsma_pkg::LANES; l++) begin
        m_coef[l] <= lane_coef[l];
        m_cond[l] <= lane_cond[l];
      end
      m_c      <= a_c;
      m_r      <= a_r;
      m_stride <= a_stride;
      m_delta  <= delta;
      m_last   <= a_last;
    end
  end

  // multiply lanes and node number
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (s_adv) begin
      s_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv && m_valid) begin
      for (int l = 0; l < gsma_pkg::LANES; l++) begin
        s_prod[l] <= m_coef[l] * $signed({1'b0, m_cond[l]});
      end
      s_self  <= gsma_pkg::SELF_W'(m_c) * gsma_pkg::SELF_W'(m_stride) +
                 gsma_pkg::SELF_W'(m_r);
      s_delta <= m_delta;
      s_last  <= m_last;
    end
  end

  // sum and output register
  logic signed [gsma_pkg::SUM_W-1:0] sum;
  logic signed [gsma_pkg::SELF_W:0]  nb;

  always_comb begin
    sum = '0;
    for (int l = 0; l < gsma_pkg::LANES; l++) begin
      sum = sum + gsma_pkg::SUM_W'(s_prod[l]);
    end
    nb = $signed({1'b0, s_self}) + (gsma_pkg::SELF_W+1)'(s_delta);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_adv) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv && s_valid) begin
      column_node    <= s_self[gsma_pkg::NODE_W-1:0];
      row_node       <= nb[gsma_pkg::NODE_W-1:0];
      entry_value    <= sum[gsma_pkg::VALUE_W-1:0];
      last_of_column <= s_last;
    end
  end

  a_node_entry_count: assert property (@(posedge clk) disable iff (rst)
    accept |=> a_valid && ($countones(a_mask) >= 4))
    else $error("node loaded with fewer than four entries");

  a_mask_nonempty: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> (a_mask != '0))
    else $error("node stage holds no entry");

  a_last_is_highest: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_column |-> (row_node >= column_node))
    else $error("last entry of a column below its own node");

endmodule

`default_nettype wire

@@ verif/gsma_column_checker.sv @@
module gsma_column_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [2:0]                           cfg_index,
  input  wire logic [gsma_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                 in_valid,
  input  wire logic                                 in_ready,
  input  wire logic [gsma_pkg::COND_W-1:0]          conductivity,
  input  wire logic                                 out_valid,
  input  wire logic                                 out_ready,
  input  wire logic [gsma_pkg::NODE_W-1:0]          column_node,
  input  wire logic [gsma_pkg::NODE_W-1:0]          row_node,
  input  wire logic signed [gsma_pkg::VALUE_W-1:0]  entry_value,
  input  wire logic                                 last_of_column,
  output int                                        pending,
  output int                                        failures,
  output int                                        entries_checked
);

  localparam int MAX_REPORTS = 20;
  localparam int SW = gsma_pkg::SIZE_W;

  typedef struct packed {
    logic [gsma_pkg::NODE_W-1:0]  col_node;
    logic [gsma_pkg::NODE_W-1:0]  row_node;
    logic [gsma_pkg::VALUE_W-1:0] value;
    logic                         last;
  } matrix_entry_t;

  logic [gsma_pkg::COND_W-1:0] column_buf [gsma_pkg::MAX_ROWS+1];
  logic [gsma_pkg::COND_W-1:0] diag_sample;
  int                          col_pos;
  int                          row_pos;
  logic [SW-1:0]               grid_cols;
  logic [SW-1:0]               grid_rows;
  logic [gsma_pkg::CFG_W-1:0]  coef_rows [gsma_pkg::LANES];
  matrix_entry_t               expected_entries [$];

  function automatic int clamp_size(input logic [SW-1:0] v, input int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic void clear_state();
    int i;
    grid_cols = SW'(1);
    grid_rows = SW'(1);
    for (i = 0; i < gsma_pkg::LANES; i++) coef_rows[i] = '0;
    for (i = 0; i <= gsma_pkg::MAX_ROWS; i++) column_buf[i] = '0;
    diag_sample = '0;
    col_pos = 0;
    row_pos = 0;
    expected_entries.delete();
    failures = 0;
    entries_checked = 0;
  endfunction

  function automatic void write_register(input logic [2:0] idx,
                                         input logic [gsma_pkg::CFG_W-1:0] data);
    case (idx)
      gsma_pkg::CFG_CELL_COLUMNS: grid_cols = data[SW-1:0];
      gsma_pkg::CFG_CELL_ROWS:    grid_rows = data[SW-1:0];
      gsma_pkg::CFG_COEF_ROW0:    coef_rows[0] = data;
      gsma_pkg::CFG_COEF_ROW1:    coef_rows[1] = data;
      gsma_pkg::CFG_COEF_ROW2:    coef_rows[2] = data;
      gsma_pkg::CFG_COEF_ROW3:    coef_rows[3] = data;
      default: ;
    endcase
  endfunction

  // one node in, its clipped 3x3 matrix column out
  function automatic void assemble_node(input logic [gsma_pkg::COND_W-1:0] current);
    int cols, rows, c, r, lc, m, dx, dy, dc, dr, k, count, self_node, nb_node;
    bit have [2][2];
    logic [gsma_pkg::COND_W-1:0] cell_cond [2][2];
    logic signed [63:0] sums [9];
    logic signed [63:0] prod;
    matrix_entry_t column_entries [9];
    cols = clamp_size(grid_cols, gsma_pkg::MAX_COLUMNS);
    rows = clamp_size(grid_rows, gsma_pkg::MAX_ROWS);
    if (col_pos > cols) col_pos = 0;
    if (row_pos > rows) row_pos = 0;
    c = col_pos;
    r = row_pos;
    have[0][0] = (c > 0) && (r > 0);
    have[0][1] = (c > 0) && (r < rows);
    have[1][0] = (c < cols) && (r > 0);
    have[1][1] = (c < cols) && (r < rows);
    cell_cond[0][0] = diag_sample;
    cell_cond[0][1] = column_buf[r];
    cell_cond[1][0] = (r > 0) ? column_buf[r-1] : '0;
    cell_cond[1][1] = current;
    for (k = 0; k < gsma_pkg::ENTRIES; k++) sums[k] = 0;
    for (dx = 0; dx < 2; dx++) begin
      for (dy = 0; dy < 2; dy++) begin
        if (have[dx][dy]) begin
          lc = (1 - dx) * 2 + (1 - dy);
          for (m = 0; m < gsma_pkg::LANES; m++) begin
            dc = dx - 1 + m / 2;
            dr = dy - 1 + m % 2;
            prod = 64'($signed(coef_rows[lc][gsma_pkg::COEF_W*m +: gsma_pkg::COEF_W]))
                   * 64'($signed({1'b0, cell_cond[dx][dy]}));
            sums[(dc + 1) * 3 + dr + 1] += prod;
          end
        end
      end
    end
    diag_sample = column_buf[r];
    column_buf[r] = current;
    self_node = c * (rows + 1) + r;
    count = 0;
    for (k = 0; k < gsma_pkg::ENTRIES; k++) begin
      dc = k / 3 - 1;
      dr = k % 3 - 1;
      if (dc < 0 && c == 0) continue;
      if (dc > 0 && c >= cols) continue;
      if (dr < 0 && r == 0) continue;
      if (dr > 0 && r >= rows) continue;
      nb_node = self_node + dc * (rows + 1) + dr;
      column_entries[count].col_node = self_node[gsma_pkg::NODE_W-1:0];
      column_entries[count].row_node = nb_node[gsma_pkg::NODE_W-1:0];
      column_entries[count].value    = sums[k][gsma_pkg::VALUE_W-1:0];
      column_entries[count].last     = 1'b0;
      count++;
    end
    column_entries[count-1].last = 1'b1;
    for (k = 0; k < count; k++) expected_entries.push_back(column_entries[k]);
    if (r >= rows) begin
      row_pos = 0;
      col_pos = (c >= cols) ? 0 : c + 1;
    end else begin
      row_pos = r + 1;
    end
  endfunction

  function automatic void flag_mismatch(input string what,
                                        input logic signed [63:0] want,
                                        input logic signed [63:0] got);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  function automatic void check_entry();
    matrix_entry_t want;
    entries_checked++;
    if (expected_entries.size() == 0) begin
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("%0t: unexpected transaction, expected none, got column %0d row %0d value %0d",
                 $time, column_node, row_node, entry_value);
      end
    end else begin
      want = expected_entries.pop_front();
      if (column_node !== want.col_node) begin
        flag_mismatch("column_node", 64'(want.col_node), 64'(column_node));
      end
      if (row_node !== want.row_node) begin
        flag_mismatch("row_node", 64'(want.row_node), 64'(row_node));
      end
      if (entry_value !== want.value) begin
        flag_mismatch("entry_value", 64'($signed(want.value)), 64'(entry_value));
      end
      if (last_of_column !== want.last) begin
        flag_mismatch("last_of_column", 64'(want.last), 64'(last_of_column));
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (cfg_we) write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) assemble_node(conductivity);
      if (out_valid && out_ready) check_entry();
    end
    pending = expected_entries.size();
  end

endmodule

@@ verif/grid_stencil_matrix_assembly_tb.sv @@
module grid_stencil_matrix_assembly_tb;

  localparam int RANDOM_NODES = 200;
  localparam int START_RUN    = 48;
  localparam int SW           = gsma_pkg::SIZE_W;
  localparam int CW           = gsma_pkg::COND_W;
  localparam int KW           = gsma_pkg::COEF_W;
  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_we = 1'b0;
  logic [2:0]                          cfg_index = gsma_pkg::CFG_CELL_COLUMNS;
  logic [gsma_pkg::CFG_W-1:0]          cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [CW-1:0]                       conductivity = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [gsma_pkg::NODE_W-1:0]         column_node;
  logic [gsma_pkg::NODE_W-1:0]         row_node;
  logic signed [gsma_pkg::VALUE_W-1:0] entry_value;
  logic                                last_of_column;

  int pending;
  int failures;
  int entries_checked;
  int nodes_sent = 0;
  int settings_used = 0;
  int burst_left = 0;
  logic [7:0] rx_tick = '0;
  logic [SW-1:0] grid_cols = SW'(1);
  logic [SW-1:0] grid_rows = SW'(1);

  always #4 clk = ~clk;

  grid_stencil_matrix_assembly dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .conductivity   (conductivity),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .column_node    (column_node),
    .row_node       (row_node),
    .entry_value    (entry_value),
    .last_of_column (last_of_column)
  );

  gsma_column_checker chk (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .conductivity    (conductivity),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .column_node     (column_node),
    .row_node        (row_node),
    .entry_value     (entry_value),
    .last_of_column  (last_of_column),
    .pending         (pending),
    .failures        (failures),
    .entries_checked (entries_checked)
  );

  // receiver: free-running, light, heavy and periodic stall stretches
  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    case (rx_tick[7:6])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(3) != 0);
      2'd2:    out_ready <= ($urandom_range(2) == 0);
      default: out_ready <= (rx_tick[2:0] == 3'd0);
    endcase
  end

  function automatic logic [CW-1:0] pick_cond();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return CW'($urandom_range(255));
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [gsma_pkg::CFG_W-1:0] pick_coef_row();
    logic [gsma_pkg::CFG_W-1:0] row;
    int j;
    for (j = 0; j < gsma_pkg::LANES; j++) begin
      case ($urandom_range(5))
        0:       row[KW*j +: KW] = 16'h8000;
        1:       row[KW*j +: KW] = 16'h7fff;
        2:       row[KW*j +: KW] = '0;
        3:       row[KW*j +: KW] = KW'($urandom_range(8191) - 4096);
        default: row[KW*j +: KW] = KW'($urandom);
      endcase
    end
    return row;
  endfunction

  function automatic logic [SW-1:0] pick_size(input int hi);
    if ($urandom_range(9) == 0) return '0;
    return SW'($urandom_range(1, hi));
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [gsma_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_grid(input logic [SW-1:0] cols, input logic [SW-1:0] rows);
    logic [gsma_pkg::CFG_W-1:0] data;
    grid_cols = cols;
    grid_rows = rows;
    data = {$urandom, $urandom};
    data[SW-1:0] = cols;
    cfg_write(gsma_pkg::CFG_CELL_COLUMNS, data);
    data = {$urandom, $urandom};
    data[SW-1:0] = rows;
    cfg_write(gsma_pkg::CFG_CELL_ROWS, data);
  endtask

  task automatic set_coefs(input logic [gsma_pkg::CFG_W-1:0] r0,
                           input logic [gsma_pkg::CFG_W-1:0] r1,
                           input logic [gsma_pkg::CFG_W-1:0] r2,
                           input logic [gsma_pkg::CFG_W-1:0] r3);
    cfg_write(gsma_pkg::CFG_COEF_ROW0, r0);
    cfg_write(gsma_pkg::CFG_COEF_ROW1, r1);
    cfg_write(gsma_pkg::CFG_COEF_ROW2, r2);
    cfg_write(gsma_pkg::CFG_COEF_ROW3, r3);
  endtask

  task automatic close_config();
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // sender works in bursts; valid only drops when a gap follows
  task automatic send_node(input logic [CW-1:0] cond);
    in_valid     <= 1'b1;
    conductivity <= cond;
    do @(posedge clk); while (!in_ready);
    nodes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid     <= 1'b0;
      conductivity <= CW'($urandom);
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 7);
    end
  endtask

  task automatic send_run(input int n);
    int i;
    for (i = 0; i < n; i++) send_node(pick_cond());
  endtask

  task automatic finish_phase();
    if (in_valid) in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int random_nodes;
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset sizes and zero coefficients
    send_node(16'h0000);
    send_node(16'hffff);
    send_node(16'h8000);
    send_node(16'h0001);
    finish_phase();

    // most negative and most positive sums
    set_grid(SW'(1), SW'(1));
    set_coefs({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    close_config();
    repeat (4) send_node(16'hffff);
    finish_phase();
    set_coefs({4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}});
    close_config();
    repeat (4) send_node(16'hffff);
    finish_phase();

    // zero columns acts as one, oversize rows clamp to the maximum
    set_grid(SW'(0), SW'(11'h7ff));
    set_coefs(pick_coef_row(), pick_coef_row(), pick_coef_row(), pick_coef_row());
    cfg_write(CFG_SPARE_A, {$urandom, $urandom});
    cfg_write(CFG_SPARE_B, {$urandom, $urandom});
    close_config();
    send_run(START_RUN);
    finish_phase();

    // interior node with full neighborhood
    set_grid(SW'(2), SW'(2));
    set_coefs(pick_coef_row(), pick_coef_row(), pick_coef_row(), pick_coef_row());
    close_config();
    send_run(9);
    finish_phase();

    // shrink columns, then rows, with a frame in flight
    set_grid(SW'(3), SW'(2));
    close_config();
    send_run(7);
    finish_phase();
    set_grid(SW'(1), SW'(2));
    close_config();
    send_run(6);
    finish_phase();
    set_grid(SW'(2), SW'(3));
    close_config();
    send_run(6);
    finish_phase();
    set_grid(SW'(2), SW'(1));
    close_config();
    send_run(6);
    finish_phase();

    // oversize columns clamp to the maximum, zero rows acts as one
    set_grid(SW'(11'h7ff), SW'(0));
    set_coefs(pick_coef_row(), pick_coef_row(), pick_coef_row(), pick_coef_row());
    close_config();
    send_run(START_RUN);
    finish_phase();

    random_nodes = 0;
    while (random_nodes < RANDOM_NODES) begin
      if (random_nodes == 0 || $urandom_range(3) != 0) set_grid(pick_size(5), pick_size(7));
      if ($urandom_range(2) != 0) begin
        set_coefs(pick_coef_row(), pick_coef_row(), pick_coef_row(), pick_coef_row());
      end
      if ($urandom_range(7) == 0) cfg_write(CFG_SPARE_A, {$urandom, $urandom});
      close_config();
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(1, 15);
      end else begin
        n = ((grid_cols == '0 ? 1 : int'(grid_cols)) + 1) *
            ((grid_rows == '0 ? 1 : int'(grid_rows)) + 1);
      end
      send_run(n);
      random_nodes += n;
      finish_phase();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d grid nodes under %0d register settings, zero and oversize sizes included",
             nodes_sent, settings_used);
    $display("%0d matrix entries compared, %0d failures", entries_checked, failures);
    if (failures == 0) begin
      $display("grid_stencil_matrix_assembly test passed");
    end else begin
      $display("grid_stencil_matrix_assembly test failed");
    end
    $finish;
  end

  initial begin
    #16000000;
    $display("grid_stencil_matrix_assembly test failed");
    $finish;
  end

endmodule
